// ----- design/pnguf_pkg.sv -----
// ----------------------------------------------------------------------------
// pnguf_pkg
// Shared widths, register indexes, filter codes and pipeline control type
// for the scanline unfilter.
// ----------------------------------------------------------------------------
package pnguf_pkg;

  localparam int LINE_MAX_DEF        = 8192;
  localparam int PIXEL_BYTES_MAX_DEF = 8;

  localparam int BYTE_W     = 8;
  localparam int BPP_W      = 4;
  localparam int LEN_W      = 14;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 14;
  localparam int KIND_W     = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_BPP = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LEN = 1'd1;

  localparam logic [KIND_W-1:0] FLT_NONE  = 3'd0;
  localparam logic [KIND_W-1:0] FLT_SUB   = 3'd1;
  localparam logic [KIND_W-1:0] FLT_UP    = 3'd2;
  localparam logic [KIND_W-1:0] FLT_AVG   = 3'd3;
  localparam logic [KIND_W-1:0] FLT_PAETH = 3'd4;

  // control that travels with a beat from the front end to reconstruction
  typedef struct packed {
    logic              row_start;
    logic [KIND_W-1:0] kind;
    logic              bad;
    logic              first_row;
    logic              last;
  } row_ctl_t;

endpackage

// ----- design/pnguf_if.sv -----
// ----------------------------------------------------------------------------
// pnguf_if
// Valid/ready stream interfaces for the unfilter input and result channels.
// ----------------------------------------------------------------------------
interface pnguf_in_if;
  logic                          valid;
  logic                          ready;
  logic [pnguf_pkg::BYTE_W-1:0]  data_byte;
  logic                          image_start;

  modport source (output valid, output data_byte, output image_start, input ready);
  modport sink   (input valid, input data_byte, input image_start, output ready);
endinterface

interface pnguf_out_if;
  logic                          valid;
  logic                          ready;
  logic [pnguf_pkg::BYTE_W-1:0]  pixel_byte;
  logic                          row_end;
  logic                          bad_filter;

  modport source (output valid, output pixel_byte, output row_end, output bad_filter,
                  input ready);
  modport sink   (input valid, input pixel_byte, input row_end, input bad_filter,
                  output ready);
endinterface

// ----- design/pnguf_row_mem.sv -----
// ----------------------------------------------------------------------------
// pnguf_row_mem
// Prior-row byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pnguf_row_mem #(
  parameter int LINE_MAX = pnguf_pkg::LINE_MAX_DEF,
  parameter int AW       = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [pnguf_pkg::BYTE_W-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr,
  output logic [pnguf_pkg::BYTE_W-1:0] rd_data
);

  logic [pnguf_pkg::BYTE_W-1:0] mem [LINE_MAX];
  logic [pnguf_pkg::BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while no new read is issued, so a stalled beat keeps it
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/pnguf_front.sv -----
// ----------------------------------------------------------------------------
// pnguf_front
// Input side: row position tracking, filter byte decode, prior-row read
// issue and the stage register that waits for the read data.
// ----------------------------------------------------------------------------
module pnguf_front #(
  parameter int LINE_MAX = pnguf_pkg::LINE_MAX_DEF,
  parameter int AW       = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  pnguf_in_if.sink                    in_s,
  input  logic [pnguf_pkg::LEN_W-1:0] line_bytes,
  input  logic                        s1_adv,
  output logic                        s1_vld,
  output pnguf_pkg::row_ctl_t         s1_ctl,
  output logic [pnguf_pkg::BYTE_W-1:0] s1_byte,
  output logic [AW-1:0]               s1_idx,
  output logic                        rd_en,
  output logic [AW-1:0]               rd_addr
);

  localparam int CW = (AW + 1 > pnguf_pkg::LEN_W) ? AW + 1 : pnguf_pkg::LEN_W;

  logic                          expect_filt_r;
  logic                          first_row_r;
  logic [pnguf_pkg::KIND_W-1:0]  kind_r;
  logic                          bad_r;
  logic [AW-1:0]                 idx_r;
  logic                          s1_vld_r;
  pnguf_pkg::row_ctl_t           s1_ctl_r;
  logic [pnguf_pkg::BYTE_W-1:0]  s1_byte_r;
  logic [AW-1:0]                 s1_idx_r;

  logic                          acc;
  logic                          is_start;
  logic                          code_bad;
  logic [CW-1:0]                 len_ext;
  logic [CW-1:0]                 len_eff;
  logic                          last;
  pnguf_pkg::row_ctl_t           ctl_nxt;

  assign in_s.ready = !s1_vld_r || s1_adv;
  assign acc        = in_s.valid && in_s.ready;
  assign is_start   = in_s.image_start || expect_filt_r;
  assign code_bad   = in_s.data_byte > pnguf_pkg::BYTE_W'(pnguf_pkg::FLT_PAETH);

  assign len_ext = CW'(line_bytes);
  always_comb begin
    if (len_ext == '0) begin
      len_eff = CW'(1);
    end else if (len_ext > CW'(LINE_MAX)) begin
      len_eff = CW'(LINE_MAX);
    end else begin
      len_eff = len_ext;
    end
  end

  assign last = (CW'(idx_r) + CW'(1)) >= len_eff;

  always_comb begin
    ctl_nxt.row_start = is_start;
    ctl_nxt.kind      = kind_r;
    ctl_nxt.bad       = bad_r;
    ctl_nxt.first_row = first_row_r;
    ctl_nxt.last      = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_filt_r <= 1'b1;
      first_row_r   <= 1'b1;
      kind_r        <= pnguf_pkg::FLT_NONE;
      bad_r         <= 1'b0;
      idx_r         <= '0;
      s1_vld_r      <= 1'b0;
    end else begin
      if (acc) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (acc) begin
        if (is_start) begin
          expect_filt_r <= 1'b0;
          idx_r         <= '0;
          bad_r         <= code_bad;
          kind_r        <= code_bad ? pnguf_pkg::FLT_NONE
                                    : in_s.data_byte[pnguf_pkg::KIND_W-1:0];
          if (in_s.image_start) begin
            first_row_r <= 1'b1;
          end
        end else if (last) begin
          expect_filt_r <= 1'b1;
          first_row_r   <= 1'b0;
          idx_r         <= '0;
        end else begin
          idx_r <= idx_r + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_ctl_r  <= ctl_nxt;
      s1_byte_r <= in_s.data_byte;
      s1_idx_r  <= idx_r;
    end
  end

  assign rd_en   = acc && !is_start;
  assign rd_addr = idx_r;

  assign s1_vld  = s1_vld_r;
  assign s1_ctl  = s1_ctl_r;
  assign s1_byte = s1_byte_r;
  assign s1_idx  = s1_idx_r;

endmodule

// ----- design/pnguf_recon.sv -----
// ----------------------------------------------------------------------------
// pnguf_recon
// Reconstruction stage: neighbor windows, predictor, write-back value and
// the result register.
// ----------------------------------------------------------------------------
module pnguf_recon #(
  parameter int PIXEL_BYTES_MAX = pnguf_pkg::PIXEL_BYTES_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [pnguf_pkg::BPP_W-1:0]  bytes_per_pixel,
  input  logic                         s1_vld,
  input  pnguf_pkg::row_ctl_t          s1_ctl,
  input  logic [pnguf_pkg::BYTE_W-1:0] s1_byte,
  input  logic [pnguf_pkg::BYTE_W-1:0] above,
  output logic                         s1_adv,
  output logic                         wr_en,
  output logic [pnguf_pkg::BYTE_W-1:0] wr_data,
  pnguf_out_if.source                  out_m
);

  localparam int WW = (PIXEL_BYTES_MAX > 1) ? $clog2(PIXEL_BYTES_MAX) : 1;
  localparam int BW = pnguf_pkg::BYTE_W;

  function automatic logic [BW:0] absdiff(input logic [BW:0] x, input logic [BW:0] y);
    absdiff = (x > y) ? x - y : y - x;
  endfunction

  function automatic logic [BW-1:0] paeth(input logic [BW-1:0] a, input logic [BW-1:0] b,
                                          input logic [BW-1:0] c);
    logic [BW:0] pa;
    logic [BW:0] pb;
    logic [BW:0] pc;
    pa = absdiff({1'b0, b}, {1'b0, c});
    pb = absdiff({1'b0, a}, {1'b0, c});
    pc = absdiff({1'b0, a} + {1'b0, b}, {c, 1'b0});
    if (pa <= pb && pa <= pc) begin
      paeth = a;
    end else if (pb <= pc) begin
      paeth = b;
    end else begin
      paeth = c;
    end
  endfunction

  logic [BW-1:0] left_w_r [PIXEL_BYTES_MAX];
  logic [BW-1:0] ul_w_r   [PIXEL_BYTES_MAX];
  logic          out_vld_r;
  logic [BW-1:0] pix_r;
  logic          row_end_r;
  logic          bad_r;

  logic [pnguf_pkg::BPP_W-1:0] bpp_eff;
  logic [WW-1:0]               sel;
  logic [BW-1:0]               a;
  logic [BW-1:0]               b;
  logic [BW-1:0]               c;
  logic [BW:0]                 ab_sum;
  logic [BW-1:0]               pred;
  logic [BW-1:0]               val;
  logic                        out_free;
  logic                        take;

  always_comb begin
    if (bytes_per_pixel == '0) begin
      bpp_eff = pnguf_pkg::BPP_W'(1);
    end else if (bytes_per_pixel > pnguf_pkg::BPP_W'(PIXEL_BYTES_MAX)) begin
      bpp_eff = pnguf_pkg::BPP_W'(PIXEL_BYTES_MAX);
    end else begin
      bpp_eff = bytes_per_pixel;
    end
  end

  assign sel    = WW'(bpp_eff - pnguf_pkg::BPP_W'(1));
  assign a      = left_w_r[sel];
  assign c      = ul_w_r[sel];
  assign b      = s1_ctl.first_row ? '0 : above;
  assign ab_sum = {1'b0, a} + {1'b0, b};

  always_comb begin
    case (s1_ctl.kind)
      pnguf_pkg::FLT_SUB:   pred = a;
      pnguf_pkg::FLT_UP:    pred = b;
      pnguf_pkg::FLT_AVG:   pred = ab_sum[BW:1];
      pnguf_pkg::FLT_PAETH: pred = paeth(a, b, c);
      default:              pred = '0;
    endcase
  end

  assign val = s1_byte + pred;

  // filter beats never wait on the result register
  assign out_free = !out_vld_r || out_m.ready;
  assign s1_adv   = s1_vld && (s1_ctl.row_start || out_free);
  assign take     = s1_adv && !s1_ctl.row_start;

  assign wr_en   = take;
  assign wr_data = val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PIXEL_BYTES_MAX; k++) begin
        left_w_r[k] <= '0;
        ul_w_r[k]   <= '0;
      end
    end else if (s1_adv) begin
      if (s1_ctl.row_start) begin
        for (int k = 0; k < PIXEL_BYTES_MAX; k++) begin
          left_w_r[k] <= '0;
          ul_w_r[k]   <= '0;
        end
      end else begin
        for (int k = PIXEL_BYTES_MAX - 1; k > 0; k--) begin
          left_w_r[k] <= left_w_r[k-1];
          ul_w_r[k]   <= ul_w_r[k-1];
        end
        left_w_r[0] <= val;
        ul_w_r[0]   <= b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (take) begin
      out_vld_r <= 1'b1;
    end else if (out_m.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pix_r     <= val;
      row_end_r <= s1_ctl.last;
      bad_r     <= s1_ctl.bad;
    end
  end

  assign out_m.valid      = out_vld_r;
  assign out_m.pixel_byte = pix_r;
  assign out_m.row_end    = row_end_r;
  assign out_m.bad_filter = bad_r;

endmodule

// ----- design/png_scanline_unfilter.sv -----
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// PNG filter reconstruction (None/Sub/Up/Average/Paeth) on a byte stream.
// ----------------------------------------------------------------------------
// pipeline: a data beat passes the stage register beside the registered prior-row
//   read, then the result register; filter beats give no result
// throughput: one byte per cycle while the result channel takes results, set by the
//   left-neighbor loop through the predictor and the one read and one write port of the row store
// reset: synchronous; expects a filter byte on a first row, registers return to
//   1, the row store is not cleared and its read data is ignored on a first row
module png_scanline_unfilter #(
  parameter int LINE_MAX        = pnguf_pkg::LINE_MAX_DEF,
  parameter int PIXEL_BYTES_MAX = pnguf_pkg::PIXEL_BYTES_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  pnguf_in_if.sink                         in_s,
  pnguf_out_if.source                      out_m,
  input  logic                             cfg_we,
  input  logic [pnguf_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [pnguf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;

  logic [pnguf_pkg::BPP_W-1:0]  bpp_r;
  logic [pnguf_pkg::LEN_W-1:0]  len_r;

  logic                         s1_adv;
  logic                         s1_vld;
  pnguf_pkg::row_ctl_t          s1_ctl;
  logic [pnguf_pkg::BYTE_W-1:0] s1_byte;
  logic [AW-1:0]                s1_idx;
  logic                         rd_en;
  logic [AW-1:0]                rd_addr;
  logic [pnguf_pkg::BYTE_W-1:0] rd_data;
  logic                         wr_en;
  logic [pnguf_pkg::BYTE_W-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r <= pnguf_pkg::BPP_W'(1);
      len_r <= pnguf_pkg::LEN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pnguf_pkg::REG_BPP: bpp_r <= cfg_wdata[pnguf_pkg::BPP_W-1:0];
        pnguf_pkg::REG_LEN: len_r <= cfg_wdata[pnguf_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  pnguf_front #(
    .LINE_MAX (LINE_MAX),
    .AW       (AW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_s       (in_s),
    .line_bytes (len_r),
    .s1_adv     (s1_adv),
    .s1_vld     (s1_vld),
    .s1_ctl     (s1_ctl),
    .s1_byte    (s1_byte),
    .s1_idx     (s1_idx),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr)
  );

  pnguf_row_mem #(
    .LINE_MAX (LINE_MAX),
    .AW       (AW)
  ) u_row_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_idx),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pnguf_recon #(
    .PIXEL_BYTES_MAX (PIXEL_BYTES_MAX)
  ) u_recon (
    .clk             (clk),
    .rst_n           (rst_n),
    .bytes_per_pixel (bpp_r),
    .s1_vld          (s1_vld),
    .s1_ctl          (s1_ctl),
    .s1_byte         (s1_byte),
    .above           (rd_data),
    .s1_adv          (s1_adv),
    .wr_en           (wr_en),
    .wr_data         (wr_data),
    .out_m           (out_m)
  );

endmodule
